// ===== hw/rtl/rtt_pkg.sv =====
`timescale 1ns / 1ps

package rtt_pkg;

    localparam int VALUE_BITS_DEF = 32;
    localparam int TEXT_DEPTH_DEF = 33;

    localparam int RADIX_BITS = 8;
    localparam int REM_BITS   = 7;
    localparam int CHAR_BITS  = 8;

    localparam logic [RADIX_BITS-1:0] RADIX_MIN   = 8'd2;
    localparam logic [RADIX_BITS-1:0] RADIX_MAX   = 8'd128;
    localparam logic [RADIX_BITS-1:0] RADIX_RESET = 8'd10;

    localparam logic [CHAR_BITS-1:0] CHAR_MINUS = 8'h2D;
    localparam logic [CHAR_BITS-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_BITS-1:0] CHAR_A     = 8'h41;
    localparam logic [CHAR_BITS-1:0] DIGIT_TEN  = 8'd10;

    function automatic logic [CHAR_BITS-1:0] digit_char(input logic [REM_BITS-1:0] d);
        logic [CHAR_BITS-1:0] dx;
        dx = {1'b0, d};
        if (dx < DIGIT_TEN) begin
            return CHAR_ZERO + dx;
        end
        return CHAR_A + dx - DIGIT_TEN;
    endfunction

endpackage

// ===== hw/rtl/rtt_divider.sv =====
`timescale 1ns / 1ps

module rtt_divider
    import rtt_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [VALUE_BITS-1:0] i_dividend,
    input  logic [RADIX_BITS-1:0] i_divisor,
    output logic                  o_done,
    output logic [VALUE_BITS-1:0] o_quotient,
    output logic [REM_BITS-1:0]   o_remainder
);

    localparam int CNT_BITS = $clog2(VALUE_BITS);

    logic                  r_busy;
    logic                  r_done;
    logic [CNT_BITS-1:0]   r_cnt;
    logic [VALUE_BITS-1:0] r_quo;
    logic [REM_BITS-1:0]   r_rem;

    logic [RADIX_BITS-1:0] w_trial;
    logic [RADIX_BITS-1:0] w_diff;
    logic                  w_ge;
    logic [VALUE_BITS-1:0] n_quo;
    logic [REM_BITS-1:0]   n_rem;

    // One quotient bit per cycle: dividend bits shift out the top, quotient bits in below.
    always_comb begin
        w_trial = {r_rem, r_quo[VALUE_BITS-1]};
        w_ge    = (w_trial >= i_divisor);
        w_diff  = w_trial - i_divisor;
        n_rem   = w_ge ? w_diff[REM_BITS-1:0] : w_trial[REM_BITS-1:0];
        n_quo   = {r_quo[VALUE_BITS-2:0], w_ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                if (r_cnt == CNT_BITS'(VALUE_BITS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
        end else if (r_busy) begin
            r_quo <= n_quo;
            r_rem <= n_rem;
        end
    end

    assign o_done      = r_done;
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;

endmodule

// ===== hw/rtl/rtt_digit_store.sv =====
`timescale 1ns / 1ps

module rtt_digit_store
    import rtt_pkg::*;
#(
    parameter int TEXT_DEPTH = TEXT_DEPTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_we,
    input  logic [$clog2(TEXT_DEPTH)-1:0] i_waddr,
    input  logic [CHAR_BITS-1:0]          i_wdata,
    input  logic [$clog2(TEXT_DEPTH)-1:0] i_raddr,
    output logic [CHAR_BITS-1:0]          o_rdata
);

    logic [CHAR_BITS-1:0] r_mem [TEXT_DEPTH];
    logic [CHAR_BITS-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/integer_to_radix_text_top.sv =====
`timescale 1ns / 1ps

// Converts a signed integer to text in the configured radix (2 to 128), one character
// per output request, most significant first, with a leading '-' for negative values
// and o_last on the final character. Digits come from a bit-serial restoring divider;
// the digits land in a TEXT_DEPTH-entry store least significant first and are then
// read back in reverse, through the store's registered read port into the output
// register. One value is worked at a time. Writes to i_cfg_data are saturated to
// 2..128; make them only while the block is idle.
module integer_to_radix_text_top
    import rtt_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEF,
    parameter int TEXT_DEPTH = TEXT_DEPTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  logic [VALUE_BITS-1:0] i_value,
    output logic                  o_stall,
    output logic                  o_valid,
    output logic [CHAR_BITS-1:0]  o_character,
    output logic                  o_last,
    input  logic                  i_stall,
    input  logic                  i_cfg_we,
    input  logic [RADIX_BITS-1:0] i_cfg_data
);

    localparam int IDX_BITS = $clog2(TEXT_DEPTH);
    localparam int CNT_BITS = $clog2(TEXT_DEPTH + 1);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_DIV  = 5'b00010,
        S_SIGN = 5'b00100,
        S_READ = 5'b01000,
        S_SHOW = 5'b10000
    } t_state;

    t_state                r_state, n_state;
    logic [RADIX_BITS-1:0] r_radix;
    logic                  r_neg, n_neg;
    logic [CNT_BITS-1:0]   r_count, n_count;
    logic [IDX_BITS-1:0]   r_idx, n_idx;
    logic                  r_load, n_load;
    logic                  r_oval, n_oval;
    logic [CHAR_BITS-1:0]  r_char;
    logic                  r_last;

    logic                  w_in_acc;
    logic                  w_out_acc;
    logic                  w_room;
    logic [VALUE_BITS-1:0] w_mag;
    logic                  w_div_start;
    logic [VALUE_BITS-1:0] w_div_dividend;
    logic                  w_div_done;
    logic [VALUE_BITS-1:0] w_div_quo;
    logic [REM_BITS-1:0]   w_div_rem;
    logic                  w_we;
    logic [CHAR_BITS-1:0]  w_wdata;
    logic [CHAR_BITS-1:0]  w_rdata;

    assign o_stall   = (r_state != S_IDLE);
    assign w_in_acc  = i_valid && (r_state == S_IDLE);
    assign w_out_acc = r_oval && !r_load && !i_stall;
    assign w_room    = (r_count < CNT_BITS'(TEXT_DEPTH));
    assign w_mag     = i_value[VALUE_BITS-1] ? (~i_value + 1'b1) : i_value;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radix <= RADIX_RESET;
        end else if (i_cfg_we) begin
            if (i_cfg_data < RADIX_MIN) begin
                r_radix <= RADIX_MIN;
            end else if (i_cfg_data > RADIX_MAX) begin
                r_radix <= RADIX_MAX;
            end else begin
                r_radix <= i_cfg_data;
            end
        end
    end

    rtt_divider #(
        .VALUE_BITS (VALUE_BITS)
    ) u_divider (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_div_start),
        .i_dividend  (w_div_dividend),
        .i_divisor   (r_radix),
        .o_done      (w_div_done),
        .o_quotient  (w_div_quo),
        .o_remainder (w_div_rem)
    );

    rtt_digit_store #(
        .TEXT_DEPTH (TEXT_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_count[IDX_BITS-1:0]),
        .i_wdata (w_wdata),
        .i_raddr (r_idx),
        .o_rdata (w_rdata)
    );

    always_comb begin
        n_state        = r_state;
        n_neg          = r_neg;
        n_count        = r_count;
        n_idx          = r_idx;
        n_load         = 1'b0;
        n_oval         = r_oval;
        w_div_start    = 1'b0;
        w_div_dividend = w_div_quo;
        w_we           = 1'b0;
        w_wdata        = digit_char(w_div_rem);
        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_neg          = i_value[VALUE_BITS-1];
                    n_count        = '0;
                    w_div_start    = 1'b1;
                    w_div_dividend = w_mag;
                    n_state        = S_DIV;
                end
            end
            S_DIV: begin
                if (w_div_done) begin
                    // Drop digits that no longer fit the store.
                    if (w_room) begin
                        w_we    = 1'b1;
                        n_count = r_count + 1'b1;
                    end
                    if (|w_div_quo) begin
                        w_div_start = 1'b1;
                    end else begin
                        n_state = S_SIGN;
                    end
                end
            end
            S_SIGN: begin
                w_wdata = CHAR_MINUS;
                if (r_neg && w_room) begin
                    w_we    = 1'b1;
                    n_count = r_count + 1'b1;
                    n_idx   = r_count[IDX_BITS-1:0];
                end else begin
                    n_idx   = IDX_BITS'(r_count - 1'b1);
                end
                n_state = S_READ;
            end
            S_READ: begin
                // Read data shows up next cycle; load it into the output register then.
                n_load  = 1'b1;
                n_oval  = 1'b1;
                n_state = S_SHOW;
            end
            S_SHOW: begin
                if (w_out_acc) begin
                    n_oval = 1'b0;
                    if (r_last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_idx   = r_idx - 1'b1;
                        n_state = S_READ;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_oval  <= 1'b0;
            r_load  <= 1'b0;
            r_count <= '0;
            r_idx   <= '0;
            r_neg   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_oval  <= n_oval;
            r_load  <= n_load;
            r_count <= n_count;
            r_idx   <= n_idx;
            r_neg   <= n_neg;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_load) begin
            r_char <= w_rdata;
            r_last <= (r_idx == '0);
        end
    end

    assign o_valid     = r_oval && !r_load;
    assign o_character = r_char;
    assign o_last      = r_last;

    a_radix_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_radix >= RADIX_MIN) && (r_radix <= RADIX_MAX))
        else $error("radix register out of range");

    a_div_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> (r_state == S_DIV))
        else $error("divider finished outside digit phase");

    a_read_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ) |-> (r_count != '0))
        else $error("readback started with empty store");

    a_last_ends_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_stall && o_last) |=> (!o_valid && (r_state == S_IDLE)))
        else $error("output continued after last character");

endmodule
